@@ src/dhf_pkg.sv @@
// ----------------------------------------------------------------------------
// dhf_pkg
// Shared types and constants of the depth hole fill filter.
// ----------------------------------------------------------------------------
package dhf_pkg;

   localparam int MAX_WIDTH  = 1024;
   localparam int COL_W      = $clog2(MAX_WIDTH);
   localparam int RING_LINES = 16;
   localparam int SLOT_W     = $clog2(RING_LINES);
   localparam int RING_DEPTH = RING_LINES * MAX_WIDTH;
   localparam int ADDR_W     = SLOT_W + COL_W;
   localparam int ROW_W      = 12;

   localparam logic [10:0] W_MIN   = 11'd3;
   localparam logic [10:0] W_MAX   = 11'(MAX_WIDTH);
   localparam logic [12:0] H_MIN   = 13'd3;
   localparam logic [12:0] H_MAX   = 13'd4096;
   localparam logic [10:0] W_RESET = 11'd640;
   localparam logic [12:0] H_RESET = 13'd480;

   localparam logic [1:0] CSR_WIDTH  = 2'd0;
   localparam logic [1:0] CSR_HEIGHT = 2'd1;
   localparam logic [1:0] CSR_HOLE   = 2'd2;

   localparam logic OP_PIXEL = 1'b0;
   localparam logic OP_DRAIN = 1'b1;

   // products of the 1-D weights 21437 / 22662
   localparam logic [28:0] WT_EE = 29'd459544969;
   localparam logic [28:0] WT_EC = 29'd485805294;
   localparam logic [28:0] WT_CC = 29'd513566244;

   typedef enum logic [2:0] {
      IDLE_ST, WIN_ST, TAIL_ST, DIVS_ST, DIVW_ST, MUL_ST, ACC_ST, FIN_ST
   } state_type;

   typedef struct packed {
      logic       tap_start;
      logic       acc_clear;
      logic       rd_en;
      logic       div_start;
      logic       mul;
      logic       acc_add;
      logic       out_load;
      logic [1:0] ti;
      logic [1:0] tj;
      logic [2:0] wi;
      logic [2:0] wj;
   } cmd_type;

   typedef struct packed {
      logic emit;
      logic div_done;
      logic out_free;
   } stat_type;

   function automatic logic [28:0] wt2(input logic [1:0] a, input logic [1:0] b);
      logic ca;
      logic cb;
      ca = (a == 2'd1);
      cb = (b == 2'd1);
      if (ca && cb) begin
         return WT_CC;
      end else if (ca || cb) begin
         return WT_EC;
      end else begin
         return WT_EE;
      end
   endfunction

endpackage

@@ src/depth_hole_fill_filter.sv @@
// ----------------------------------------------------------------------------
// depth_hole_fill_filter
// Depth hole filling by masked 5x5 mean, then 3x3 Gaussian smoothing.
// ----------------------------------------------------------------------------
// Pixels enter on the req_ channel in raster order (operation 0); drain words
// (operation 1) flush the outputs still owed once a frame has fully arrived.
// Results leave on the rsp_ channel with line and frame end flags, lagging
// the input by three lines and three pixels. Sizes and the hole level are set
// through the csr_ write port; the user must write them only while the block
// is idle, which the block does not enforce. Such a write restarts the raster
// counters and drops pending outputs. A word that yields a result keeps the
// sequencer busy for nine blur taps, each 25 single-port reads of the line
// ring plus a serial divide and a multiply-accumulate. req_ready is high
// whenever the sequencer is idle, also while a finished word waits in the
// output register; if rsp_ready is held low the sequencer waits at the end
// of the next result. Reset clears counters and the output register; the
// line ring has no reset and its data is only used where pixels of the
// current frame have been written.
// ----------------------------------------------------------------------------
module depth_hole_fill_filter (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_wr_en,
   input  logic [1:0]  csr_index,
   input  logic [12:0] csr_wr_data,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic        req_operation,
   input  logic [7:0]  req_pixel_in,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [7:0]  rsp_depth_out,
   output logic        rsp_line_end,
   output logic        rsp_frame_end
);

   dhf_pkg::cmd_type  cmd;
   dhf_pkg::stat_type stat;
   logic              req_accept;

   assign req_accept = req_valid && req_ready;

   dhf_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_accept (req_accept),
      .stat       (stat),
      .cmd        (cmd),
      .req_ready  (req_ready)
   );

   dhf_dpath u_dpath (
      .clock         (clock),
      .reset         (reset),
      .csr_wr_en     (csr_wr_en),
      .csr_index     (csr_index),
      .csr_wr_data   (csr_wr_data),
      .req_accept    (req_accept),
      .req_operation (req_operation),
      .req_pixel_in  (req_pixel_in),
      .cmd           (cmd),
      .stat          (stat),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_depth_out (rsp_depth_out),
      .rsp_line_end  (rsp_line_end),
      .rsp_frame_end (rsp_frame_end)
   );

endmodule

@@ src/dhf_div.sv @@
// ----------------------------------------------------------------------------
// dhf_div
// Restoring divider, one quotient bit per cycle, for the window mean.
// ----------------------------------------------------------------------------
module dhf_div (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic [20:0] num,
   input  logic [4:0]  den,
   output logic        done,
   output logic [20:0] quot
);

   logic        busy_ff, busy_in;
   logic        done_ff, done_in;
   logic [4:0]  cnt_ff, cnt_in;
   logic [4:0]  rem_ff, rem_in;
   logic [20:0] q_ff, q_in;
   logic [5:0]  rem2;
   logic        ge;

   always_comb begin
      rem2    = {rem_ff, q_ff[20]};
      ge      = rem2 >= {1'b0, den};
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      q_in    = q_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = 5'd21;
         rem_in  = 5'd0;
         q_in    = num;
      end else if (busy_ff) begin
         rem_in = ge ? 5'(rem2 - {1'b0, den}) : rem2[4:0];
         q_in   = {q_ff[19:0], ge};
         cnt_in = cnt_ff - 5'd1;
         if (cnt_ff == 5'd1) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= 5'd0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      rem_ff <= rem_in;
      q_ff   <= q_in;
   end

   assign done = done_ff;
   assign quot = q_ff;

endmodule

@@ src/dhf_dpath.sv @@
// ----------------------------------------------------------------------------
// dhf_dpath
// Line ring, raster counters, window accumulation, blur MAC and output word.
// ----------------------------------------------------------------------------
module dhf_dpath (
   input  logic                clock,
   input  logic                reset,
   input  logic                csr_wr_en,
   input  logic [1:0]          csr_index,
   input  logic [12:0]         csr_wr_data,
   input  logic                req_accept,
   input  logic                req_operation,
   input  logic [7:0]          req_pixel_in,
   input  dhf_pkg::cmd_type    cmd,
   output dhf_pkg::stat_type   stat,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output logic [7:0]          rsp_depth_out,
   output logic                rsp_line_end,
   output logic                rsp_frame_end
);

   logic [10:0] fw_ff;
   logic [12:0] fh_ff;
   logic [7:0]  hl_ff;
   logic [10:0] w_use;
   logic [12:0] h_use;
   logic [12:0] lag;
   logic        restart;

   logic [dhf_pkg::COL_W-1:0]  in_col_ff, out_col_ff;
   logic [dhf_pkg::ROW_W-1:0]  in_row_ff, out_row_ff;
   logic [dhf_pkg::SLOT_W-1:0] in_slot_ff, out_slot_ff;
   logic                       in_tog_ff, out_tog_ff;
   logic [12:0]                pend_ff;

   logic [10:0] col_nx;
   logic [12:0] row_nx;
   logic        col_wrap, row_wrap, tog_nx, is_px;
   logic [12:0] pend_nx;
   logic [10:0] ocol_nx;
   logic [12:0] orow_nx;
   logic        ocol_wrap, orow_wrap;
   logic        emit_w, div_done_w, out_free_w;

   logic [7:0]  raw_mem [0:dhf_pkg::RING_DEPTH-1];
   logic [7:0]  rd_data_ff;
   logic        rdv_ff, ctr_ff;
   logic [dhf_pkg::ADDR_W-1:0] rd_addr;
   logic [dhf_pkg::SLOT_W-1:0] rd_slot;

   logic signed [14:0] r_s, c_s, h_s, w_s, tr0, tc0, trow, tcol, rr, cc, dlt;
   logic        in_range, is_ctr;

   logic [12:0] sum_ff;
   logic [4:0]  cnt_ff;
   logic [7:0]  ctr_val_ff;
   logic [20:0] num;
   logic [20:0] quot;
   logic [15:0] filled;
   logic [44:0] prod_ff;
   logic [47:0] acc_ff;
   logic [48:0] tot;
   logic [8:0]  val9;

   logic        rsp_valid_ff;
   logic [7:0]  depth_ff;
   logic        line_end_ff, frame_end_ff;

   always_comb begin
      w_use = (fw_ff < dhf_pkg::W_MIN) ? dhf_pkg::W_MIN :
              (fw_ff > dhf_pkg::W_MAX) ? dhf_pkg::W_MAX : fw_ff;
      h_use = (fh_ff < dhf_pkg::H_MIN) ? dhf_pkg::H_MIN :
              (fh_ff > dhf_pkg::H_MAX) ? dhf_pkg::H_MAX : fh_ff;
      lag   = 13'({w_use, 1'b0}) + 13'(w_use) + 13'd3;
   end

   assign restart = csr_wr_en && (csr_index == dhf_pkg::CSR_WIDTH ||
                    csr_index == dhf_pkg::CSR_HEIGHT || csr_index == dhf_pkg::CSR_HOLE);

   always_ff @(posedge clock) begin
      if (reset) begin
         fw_ff <= dhf_pkg::W_RESET;
         fh_ff <= dhf_pkg::H_RESET;
         hl_ff <= 8'd0;
      end else if (csr_wr_en) begin
         case (csr_index)
            dhf_pkg::CSR_WIDTH:  fw_ff <= csr_wr_data[10:0];
            dhf_pkg::CSR_HEIGHT: fh_ff <= csr_wr_data;
            dhf_pkg::CSR_HOLE:   hl_ff <= csr_wr_data[7:0];
            default: ;
         endcase
      end
   end

   // emission decision for the word being accepted
   always_comb begin
      is_px     = (req_operation == dhf_pkg::OP_PIXEL);
      col_nx    = {1'b0, in_col_ff} + 11'd1;
      col_wrap  = col_nx >= w_use;
      row_nx    = {1'b0, in_row_ff} + 13'd1;
      row_wrap  = row_nx >= h_use;
      tog_nx    = in_tog_ff ^ (col_wrap & row_wrap);
      pend_nx   = pend_ff + 13'd1;
      ocol_nx   = {1'b0, out_col_ff} + 11'd1;
      ocol_wrap = ocol_nx >= w_use;
      orow_nx   = {1'b0, out_row_ff} + 13'd1;
      orow_wrap = orow_nx >= h_use;
      if (is_px) begin
         emit_w = (pend_nx > lag) || (tog_nx != out_tog_ff);
      end else begin
         emit_w = (pend_ff != 13'd0) && (in_tog_ff != out_tog_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset || restart) begin
         in_col_ff   <= '0;
         in_row_ff   <= '0;
         in_slot_ff  <= '0;
         in_tog_ff   <= 1'b0;
         out_col_ff  <= '0;
         out_row_ff  <= '0;
         out_slot_ff <= '0;
         out_tog_ff  <= 1'b0;
         pend_ff     <= 13'd0;
      end else if (req_accept && is_px) begin
         pend_ff <= pend_nx;
         if (col_wrap) begin
            in_col_ff  <= '0;
            in_slot_ff <= in_slot_ff + 1'b1;
            in_row_ff  <= row_wrap ? '0 : row_nx[dhf_pkg::ROW_W-1:0];
            in_tog_ff  <= tog_nx;
         end else begin
            in_col_ff <= col_nx[dhf_pkg::COL_W-1:0];
         end
      end else if (cmd.out_load) begin
         pend_ff <= pend_ff - 13'd1;
         if (ocol_wrap) begin
            out_col_ff  <= '0;
            out_slot_ff <= out_slot_ff + 1'b1;
            out_row_ff  <= orow_wrap ? '0 : orow_nx[dhf_pkg::ROW_W-1:0];
            if (orow_wrap) begin
               out_tog_ff <= ~out_tog_ff;
            end
         end else begin
            out_col_ff <= ocol_nx[dhf_pkg::COL_W-1:0];
         end
      end
   end

   // window coordinates: tap centre mirrored, then 5x5 offset masked outside the frame
   always_comb begin
      r_s  = signed'(15'(out_row_ff));
      c_s  = signed'(15'(out_col_ff));
      h_s  = signed'(15'(h_use));
      w_s  = signed'(15'(w_use));
      tr0  = r_s + signed'(15'(cmd.ti)) - 15'sd1;
      tc0  = c_s + signed'(15'(cmd.tj)) - 15'sd1;
      trow = (tr0 < 15'sd0) ? 15'sd1 : (tr0 >= h_s) ? h_s - 15'sd2 : tr0;
      tcol = (tc0 < 15'sd0) ? 15'sd1 : (tc0 >= w_s) ? w_s - 15'sd2 : tc0;
      rr   = trow + signed'(15'(cmd.wi)) - 15'sd2;
      cc   = tcol + signed'(15'(cmd.wj)) - 15'sd2;
      in_range = (rr >= 15'sd0) && (rr < h_s) && (cc >= 15'sd0) && (cc < w_s);
      is_ctr   = (cmd.wi == 3'd2) && (cmd.wj == 3'd2);
      dlt      = rr - r_s;
      rd_slot  = out_slot_ff + dlt[dhf_pkg::SLOT_W-1:0];
      rd_addr  = {rd_slot, cc[dhf_pkg::COL_W-1:0]};
   end

   always_ff @(posedge clock) begin
      if (req_accept && is_px) begin
         raw_mem[{in_slot_ff, in_col_ff}] <= req_pixel_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.rd_en) begin
         rd_data_ff <= raw_mem[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rdv_ff <= 1'b0;
         ctr_ff <= 1'b0;
      end else begin
         rdv_ff <= cmd.rd_en && in_range;
         ctr_ff <= cmd.rd_en && is_ctr;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.tap_start) begin
         sum_ff <= 13'd0;
         cnt_ff <= 5'd0;
      end else if (rdv_ff && rd_data_ff > hl_ff) begin
         sum_ff <= sum_ff + 13'(rd_data_ff);
         cnt_ff <= cnt_ff + 5'd1;
      end
      if (ctr_ff) begin
         ctr_val_ff <= rd_data_ff;
      end
   end

   assign num = {sum_ff, 8'd0} + 21'(cnt_ff >> 1);

   dhf_div u_div (
      .clock (clock),
      .reset (reset),
      .start (cmd.div_start),
      .num   (num),
      .den   (cnt_ff),
      .done  (div_done_w),
      .quot  (quot)
   );

   // no valid pixel in the window: keep the raw centre
   assign filled = (cnt_ff == 5'd0) ? {ctr_val_ff, 8'd0} : quot[15:0];

   always_ff @(posedge clock) begin
      if (cmd.mul) begin
         prod_ff <= dhf_pkg::wt2(cmd.ti, cmd.tj) * filled;
      end
      if (cmd.acc_clear) begin
         acc_ff <= 48'd0;
      end else if (cmd.acc_add) begin
         acc_ff <= acc_ff + 48'(prod_ff);
      end
   end

   assign tot  = {1'b0, acc_ff} + (49'd1 << 39);
   assign val9 = tot[48:40];

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.out_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
      if (cmd.out_load) begin
         depth_ff     <= val9[8] ? 8'hFF : val9[7:0];
         line_end_ff  <= ({1'b0, out_col_ff} == w_use - 11'd1);
         frame_end_ff <= ({1'b0, out_col_ff} == w_use - 11'd1) &&
                         ({1'b0, out_row_ff} == h_use - 13'd1);
      end
   end

   assign out_free_w    = !rsp_valid_ff || rsp_ready;
   assign stat          = {emit_w, div_done_w, out_free_w};
   assign rsp_valid     = rsp_valid_ff;
   assign rsp_depth_out = depth_ff;
   assign rsp_line_end  = line_end_ff;
   assign rsp_frame_end = frame_end_ff;

   a_load_free: assert property (@(posedge clock) disable iff (reset)
      cmd.out_load |-> (!rsp_valid_ff || rsp_ready))
      else $error("output word overwritten");

   a_pend_bound: assert property (@(posedge clock) disable iff (reset)
      pend_ff <= lag + 13'd1)
      else $error("pending count past lag");

   a_centre_in: assert property (@(posedge clock) disable iff (reset)
      (cmd.rd_en && is_ctr) |-> in_range)
      else $error("tap centre outside frame");

endmodule

@@ src/dhf_ctrl.sv @@
// ----------------------------------------------------------------------------
// dhf_ctrl
// Sequencer: 9 blur taps, each a 25-read window, divide and MAC.
// ----------------------------------------------------------------------------
module dhf_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_accept,
   input  dhf_pkg::stat_type stat,
   output dhf_pkg::cmd_type  cmd,
   output logic              req_ready
);

   dhf_pkg::state_type state_ff, state_in;
   logic [1:0] ti_ff, ti_in, tj_ff, tj_in;
   logic [2:0] wi_ff, wi_in, wj_ff, wj_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= dhf_pkg::IDLE_ST;
         ti_ff    <= 2'd0;
         tj_ff    <= 2'd0;
         wi_ff    <= 3'd0;
         wj_ff    <= 3'd0;
      end else begin
         state_ff <= state_in;
         ti_ff    <= ti_in;
         tj_ff    <= tj_in;
         wi_ff    <= wi_in;
         wj_ff    <= wj_in;
      end
   end

   always_comb begin
      state_in      = state_ff;
      ti_in         = ti_ff;
      tj_in         = tj_ff;
      wi_in         = wi_ff;
      wj_in         = wj_ff;
      cmd           = '0;
      cmd.ti        = ti_ff;
      cmd.tj        = tj_ff;
      cmd.wi        = wi_ff;
      cmd.wj        = wj_ff;
      case (state_ff)
         dhf_pkg::IDLE_ST: begin
            if (req_accept && stat.emit) begin
               cmd.tap_start = 1'b1;
               cmd.acc_clear = 1'b1;
               ti_in    = 2'd0;
               tj_in    = 2'd0;
               wi_in    = 3'd0;
               wj_in    = 3'd0;
               state_in = dhf_pkg::WIN_ST;
            end
         end
         dhf_pkg::WIN_ST: begin
            cmd.rd_en = 1'b1;
            if (wj_ff == 3'd4) begin
               wj_in = 3'd0;
               if (wi_ff == 3'd4) begin
                  wi_in    = 3'd0;
                  state_in = dhf_pkg::TAIL_ST;
               end else begin
                  wi_in = wi_ff + 3'd1;
               end
            end else begin
               wj_in = wj_ff + 3'd1;
            end
         end
         dhf_pkg::TAIL_ST: state_in = dhf_pkg::DIVS_ST;
         dhf_pkg::DIVS_ST: begin
            cmd.div_start = 1'b1;
            state_in      = dhf_pkg::DIVW_ST;
         end
         dhf_pkg::DIVW_ST: begin
            if (stat.div_done) begin
               state_in = dhf_pkg::MUL_ST;
            end
         end
         dhf_pkg::MUL_ST: begin
            cmd.mul  = 1'b1;
            state_in = dhf_pkg::ACC_ST;
         end
         dhf_pkg::ACC_ST: begin
            cmd.acc_add = 1'b1;
            if (tj_ff == 2'd2) begin
               tj_in = 2'd0;
               if (ti_ff == 2'd2) begin
                  state_in = dhf_pkg::FIN_ST;
               end else begin
                  ti_in         = ti_ff + 2'd1;
                  cmd.tap_start = 1'b1;
                  state_in      = dhf_pkg::WIN_ST;
               end
            end else begin
               tj_in         = tj_ff + 2'd1;
               cmd.tap_start = 1'b1;
               state_in      = dhf_pkg::WIN_ST;
            end
         end
         dhf_pkg::FIN_ST: begin
            if (stat.out_free) begin
               cmd.out_load = 1'b1;
               state_in     = dhf_pkg::IDLE_ST;
            end
         end
         default: state_in = dhf_pkg::IDLE_ST;
      endcase
   end

   assign req_ready = (state_ff == dhf_pkg::IDLE_ST);

endmodule
